### hw/rtl/pbsf_pkg.sv
package pbsf_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BYTE        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_ESCAPE_CODE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_ESCAPE_CODE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_WORD         = 3'd4;

  localparam logic [7:0]  RST_START_BYTE         = 8'h02;
  localparam logic [7:0]  RST_ESCAPE_BYTE        = 8'h1B;
  localparam logic [7:0]  RST_START_ESCAPE_CODE  = 8'h82;
  localparam logic [7:0]  RST_ESCAPE_ESCAPE_CODE = 8'h9B;
  localparam logic [15:0] RST_CHECK_WORD         = 16'h1234;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned SLOTS = 3;
  localparam logic [1:0] SLOT_DATA = 2'd0;
  localparam logic [1:0] SLOT_LO   = 2'd1;
  localparam logic [1:0] SLOT_HI   = 2'd2;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] escape_byte;
  } line_cfg_t;

  typedef struct packed {
    logic                  first;
    logic                  final_mark;
    logic [SLOTS-1:0]      esc;
    logic [SLOTS-1:0][7:0] val;
  } job_t;

endpackage

### hw/rtl/pbsf_front.sv
module pbsf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pbsf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                        data_byte,
  input  logic                              frame_first,
  input  logic                              frame_final,
  output pbsf_pkg::job_t                    job,
  output pbsf_pkg::line_cfg_t               line_cfg
);

  logic [7:0]  start_byte;
  logic [7:0]  escape_byte;
  logic [7:0]  start_escape_code;
  logic [7:0]  escape_escape_code;
  logic [15:0] check_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte         <= pbsf_pkg::RST_START_BYTE;
      escape_byte        <= pbsf_pkg::RST_ESCAPE_BYTE;
      start_escape_code  <= pbsf_pkg::RST_START_ESCAPE_CODE;
      escape_escape_code <= pbsf_pkg::RST_ESCAPE_ESCAPE_CODE;
      check_word         <= pbsf_pkg::RST_CHECK_WORD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbsf_pkg::CFG_START_BYTE:         start_byte         <= cfg_data[7:0];
        pbsf_pkg::CFG_ESCAPE_BYTE:        escape_byte        <= cfg_data[7:0];
        pbsf_pkg::CFG_START_ESCAPE_CODE:  start_escape_code  <= cfg_data[7:0];
        pbsf_pkg::CFG_ESCAPE_ESCAPE_CODE: escape_escape_code <= cfg_data[7:0];
        pbsf_pkg::CFG_CHECK_WORD:         check_word         <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [pbsf_pkg::SLOTS-1:0][7:0] raw;

  assign raw[pbsf_pkg::SLOT_DATA] = data_byte;
  assign raw[pbsf_pkg::SLOT_LO]   = check_word[7:0];
  assign raw[pbsf_pkg::SLOT_HI]   = check_word[15:8];

  always_comb begin
    job.first      = frame_first;
    job.final_mark = frame_final;
    for (int i = 0; i < pbsf_pkg::SLOTS; i++) begin
      job.esc[i] = (raw[i] == start_byte) || (raw[i] == escape_byte);
      if (raw[i] == start_byte) begin
        job.val[i] = start_escape_code;
      end else if (raw[i] == escape_byte) begin
        job.val[i] = escape_escape_code;
      end else begin
        job.val[i] = raw[i];
      end
    end
  end

  assign line_cfg.start_byte  = start_byte;
  assign line_cfg.escape_byte = escape_byte;

endmodule

### hw/rtl/pbsf_queue.sv
module pbsf_queue #(
  parameter int unsigned DEPTH = pbsf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbsf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output pbsf_pkg::job_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pbsf_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

### hw/rtl/pbsf_back.sv
module pbsf_back (
  input  logic                clk,
  input  logic                rst,
  input  pbsf_pkg::line_cfg_t line_cfg,
  input  logic                head_valid,
  input  pbsf_pkg::job_t      head,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                frame_done
);

  typedef enum logic [1:0] {PH_HEAD, PH_BYTE, PH_CODE} phase_t;

  phase_t     phase;
  phase_t     phase_next;
  phase_t     ph_eff;
  logic [1:0] slot;
  logic [1:0] slot_next;
  logic       advance;
  logic       slot_done;
  logic       item_end;
  logic [7:0] emit_byte;

  assign advance = head_valid && (!res_valid || !res_stall);
  assign pop     = advance && item_end;

  always_comb begin
    ph_eff = phase;
    if (phase == PH_HEAD && !head.first) begin
      ph_eff = PH_BYTE;
    end
    emit_byte  = head.val[slot];
    slot_done  = 1'b0;
    phase_next = phase;
    slot_next  = slot;
    unique case (ph_eff)
      PH_HEAD: begin
        emit_byte  = line_cfg.start_byte;
        phase_next = PH_BYTE;
      end
      PH_BYTE: begin
        if (head.esc[slot]) begin
          emit_byte  = line_cfg.escape_byte;
          phase_next = PH_CODE;
        end else begin
          slot_done = 1'b1;
        end
      end
      PH_CODE: begin
        slot_done = 1'b1;
      end
      default: ;
    endcase
    item_end = slot_done &&
               ((slot == pbsf_pkg::SLOT_HI) ||
                (slot == pbsf_pkg::SLOT_DATA && !head.final_mark));
    if (slot_done) begin
      if (item_end) begin
        phase_next = PH_HEAD;
        slot_next  = pbsf_pkg::SLOT_DATA;
      end else begin
        phase_next = PH_BYTE;
        slot_next  = slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      slot       <= pbsf_pkg::SLOT_DATA;
      res_valid  <= 1'b0;
      run_last   <= 1'b0;
      frame_done <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      slot       <= slot_next;
      res_valid  <= 1'b1;
      run_last   <= item_end;
      frame_done <= item_end && head.final_mark;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= emit_byte;
    end
  end

endmodule

### hw/rtl/parcel_byte_stuffing_framer_top.sv
// Parcel byte-stuffing framer.
// Item channel: data_byte with frame_first / frame_final, taken when item_valid is
// high and item_stall is low. Result channel: out_byte, run_last, frame_done, taken
// when res_valid is high and res_stall is low. Config: cfg_index / cfg_data written
// when cfg_valid and cfg_ready are high (cfg_ready is always high); write only idle.
// Each item becomes 1 to 7 line bytes: optional start byte, the stuffed data byte
// and, on a final item, the stuffed check word, low byte first. run_last marks the
// last byte of an item, frame_done the last byte of a frame.
// The front stage classifies an item in the cycle it is taken and writes it into a
// QUEUE_DEPTH-entry queue; the back sequencer sends one line byte per cycle, when
// not held by res_stall, into the output register. The first byte of an item goes
// through its queue entry and then the output register; an item occupies the back
// for all of its line bytes, so the line byte rate of one per cycle sets the
// throughput. item_stall rises when the queue is full. While res_valid and
// res_stall are high the output register holds its byte and the back waits; the
// front keeps taking items until the queue fills. Reset empties the queue and
// the output register and loads the default configuration.
module parcel_byte_stuffing_framer_top #(
  parameter int unsigned QUEUE_DEPTH = pbsf_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             frame_first,
  input  logic                             frame_final,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [7:0]                       out_byte,
  output logic                             run_last,
  output logic                             frame_done
);

  pbsf_pkg::job_t      job;
  pbsf_pkg::job_t      head;
  pbsf_pkg::line_cfg_t line_cfg;
  logic                queue_full;
  logic                head_valid;
  logic                pop;

  assign item_stall = queue_full;

  pbsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_byte   (data_byte),
    .frame_first (frame_first),
    .frame_final (frame_final),
    .job         (job),
    .line_cfg    (line_cfg)
  );

  pbsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (item_valid),
    .push_job   (job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pbsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .line_cfg   (line_cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_done (frame_done)
  );

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_done |-> run_last)
    else $error("frame_done without run_last");

  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && !run_last |=> res_valid)
    else $error("gap inside the bytes of one item");

  a_pop_on_run_end: assert property (@(posedge clk) disable iff (rst)
    pop |=> res_valid && run_last)
    else $error("queue popped without ending an item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule
